FILE: hdl/fps_pkg.sv
// ----------------------------------------------------------------------------
// fps_pkg
// Shared types and constants for the frame pacing scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fps_pkg;

    localparam int NUM_SPEEDS  = 5;
    localparam int THR_W       = 16;
    localparam int TIME_W      = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int DIV_STEPS   = TIME_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [2:0] MAX_SPEED = 3'd4;

    localparam logic [THR_W-1:0] THR_RESET [NUM_SPEEDS] = '{
        16'h0032, 16'h0064, 16'h0096, 16'h00fa, 16'h01f4
    };

    typedef enum logic [1:0] {
        OUT_DELAYED   = 2'd0,
        OUT_SKIPPED   = 2'd1,
        OUT_NO_DEVICE = 2'd2,
        OUT_TICKED    = 2'd3
    } t_outcome;

    typedef enum logic [1:0] {
        MODE_RUNNING = 2'd0,
        MODE_PAUSED  = 2'd1,
        MODE_RESUMED = 2'd2,
        MODE_OTHER   = 2'd3
    } t_run_mode;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic eval;
        logic cmp;
        logic step;
        logic commit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic delayed;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

FILE: hdl/fps_ctrl.sv
// ----------------------------------------------------------------------------
// fps_ctrl
// Sequencer: accept, elapsed time, compare, remainder loop, result write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fps_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire fps_pkg::t_sts i_sts,
    output fps_pkg::t_cmd      o_cmd
);
    import fps_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_CMP,
        S_DIV,
        S_OUT
    } t_state;

    t_state               r_state;
    logic [DIV_CNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_cnt <= DIV_CNT_W'(DIV_STEPS - 1);
                    if (i_sts.delayed) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_sts.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // no item is taken while reset is held
    assign o_in_ready   = (r_state == S_IDLE) && i_rst_n;
    assign o_cmd.load   = (r_state == S_IDLE) && i_rst_n && i_in_valid;
    assign o_cmd.eval   = (r_state == S_EVAL);
    assign o_cmd.cmp    = (r_state == S_CMP);
    assign o_cmd.step   = (r_state == S_DIV);
    assign o_cmd.commit = (r_state == S_OUT) && i_sts.out_free;

endmodule

`default_nettype wire

FILE: hdl/fps_dp.sv
// ----------------------------------------------------------------------------
// fps_dp
// Datapath: thresholds, pacing state, elapsed time, bit-serial remainder,
// result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fps_dp (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire fps_pkg::t_cmd                       i_cmd,
    output fps_pkg::t_sts                            o_sts,
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [fps_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [fps_pkg::THR_W-1:0]           i_cfg_data,
    input  wire logic [fps_pkg::TIME_W-1:0]          i_now_time,
    input  wire logic                                i_device_present,
    input  wire logic [2:0]                          i_speed_select,
    input  wire logic                                i_mode_load,
    input  wire logic [1:0]                          i_mode_value,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic [1:0]                               o_outcome,
    output logic [2:0]                               o_sleep_time,
    output logic                                     o_poll_input,
    output logic [2:0]                               o_sim_steps,
    output logic                                     o_render_now,
    output logic [fps_pkg::TIME_W-1:0]               o_frames_done
);
    import fps_pkg::*;

    logic [THR_W-1:0]  r_thr [NUM_SPEEDS];
    logic [TIME_W-1:0] r_prev;
    logic [THR_W-1:0]  r_left;
    logic [TIME_W-1:0] r_frames;
    t_run_mode         r_mode;

    logic [TIME_W-1:0] r_now;
    logic              r_dev;
    logic [2:0]        r_speed;
    logic [TIME_W-1:0] r_elapsed;
    logic [THR_W-1:0]  r_sel_thr;
    logic              r_delayed;
    logic              r_poll;
    logic [2:0]        r_sleep;
    logic [THR_W-1:0]  r_rem;
    logic [TIME_W-1:0] r_dvd;

    logic              r_out_valid;
    t_outcome          r_outcome;
    logic [2:0]        r_o_sleep;
    logic              r_o_poll;
    logic [2:0]        r_o_steps;
    logic              r_o_render;
    logic [TIME_W-1:0] r_o_frames;

    logic [TIME_W-1:0]        now3, prev3, n_elapsed;
    logic signed [TIME_W+1:0] diff;
    logic                     n_delayed, n_poll;
    logic [2:0]               n_sleep;
    logic [THR_W:0]           div_t;
    logic [THR_W-1:0]         n_rem;
    logic [2:0]               speed_sat;
    logic [4:0]               rem_small;

    logic                     run_ok;
    t_outcome                 n_outcome;
    logic [2:0]               n_steps;
    logic                     n_render;
    logic [TIME_W-1:0]        n_frames;
    t_run_mode                n_mode;

    assign speed_sat = (i_speed_select > MAX_SPEED) ? MAX_SPEED : i_speed_select;

    assign now3      = {r_now[TIME_W-2:0], 1'b0} + r_now;
    assign prev3     = {r_prev[TIME_W-2:0], 1'b0} + r_prev;
    assign n_elapsed = now3 - prev3 + {{(TIME_W-THR_W){1'b0}}, r_left};

    // threshold minus elapsed, full precision
    assign diff = $signed({{(TIME_W+2-THR_W){1'b0}}, r_sel_thr})
                - $signed({{2{r_elapsed[TIME_W-1]}}, r_elapsed});
    assign n_delayed = (diff > 0);
    assign n_poll    = ($signed({{(TIME_W+1-THR_W){1'b0}}, r_thr[0]})
                        <= $signed({r_elapsed[TIME_W-1], r_elapsed}));
    assign rem_small = diff[4:0] - 5'd10;

    always_comb begin
        n_sleep = 3'd0;
        if (diff > 20) begin
            n_sleep = 3'd5;
        end else if (diff > 10) begin
            unique case (rem_small)
                5'd1, 5'd2:         n_sleep = 3'd1;
                5'd3, 5'd4, 5'd5:   n_sleep = 3'd2;
                5'd6, 5'd7, 5'd8:   n_sleep = 3'd3;
                default:            n_sleep = 3'd4;
            endcase
        end
    end

    // one dividend bit shifted into the remainder per step
    assign div_t = {r_rem, r_dvd[TIME_W-1]};
    assign n_rem = (div_t >= {1'b0, r_sel_thr}) ? THR_W'(div_t - {1'b0, r_sel_thr})
                                                : div_t[THR_W-1:0];

    assign run_ok = (r_mode == MODE_RUNNING) || (r_mode == MODE_RESUMED);

    always_comb begin
        n_outcome = OUT_DELAYED;
        n_steps   = 3'd0;
        n_render  = 1'b0;
        n_frames  = r_frames;
        n_mode    = r_mode;
        if (!r_delayed) begin
            if (!run_ok) begin
                n_outcome = OUT_SKIPPED;
            end else begin
                n_steps = r_speed + 3'd1;
                if (!r_dev) begin
                    n_outcome = OUT_NO_DEVICE;
                end else begin
                    n_outcome = OUT_TICKED;
                    n_render  = 1'b1;
                    n_frames  = r_frames + 1'b1;
                    if (r_mode == MODE_RESUMED) begin
                        n_mode = MODE_PAUSED;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr       <= THR_RESET;
            r_prev      <= '0;
            r_left      <= '0;
            r_frames    <= '0;
            r_mode      <= MODE_RUNNING;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en && (i_cfg_index < CFG_IDX_W'(NUM_SPEEDS))) begin
                r_thr[i_cfg_index] <= i_cfg_data;
            end
            if (i_cmd.load && i_mode_load) begin
                r_mode <= t_run_mode'(i_mode_value);
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
                r_frames    <= n_frames;
                r_mode      <= n_mode;
                if (!r_delayed) begin
                    r_prev <= r_now;
                    r_left <= (r_sel_thr == '0) ? '0 : r_rem;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_now   <= i_now_time;
            r_dev   <= i_device_present;
            r_speed <= speed_sat;
        end
        if (i_cmd.eval) begin
            r_elapsed <= n_elapsed;
            r_sel_thr <= r_thr[r_speed];
        end
        if (i_cmd.cmp) begin
            r_delayed <= n_delayed;
            r_poll    <= n_poll;
            r_sleep   <= n_delayed ? n_sleep : 3'd0;
            r_dvd     <= r_elapsed;
            r_rem     <= '0;
        end
        if (i_cmd.step) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[TIME_W-2:0], 1'b0};
        end
        if (i_cmd.commit) begin
            r_outcome  <= n_outcome;
            r_o_sleep  <= r_sleep;
            r_o_poll   <= r_poll;
            r_o_steps  <= n_steps;
            r_o_render <= n_render;
            r_o_frames <= n_frames;
        end
    end

    assign o_sts.delayed  = n_delayed;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_outcome     = r_outcome;
    assign o_sleep_time  = r_o_sleep;
    assign o_poll_input  = r_o_poll;
    assign o_sim_steps   = r_o_steps;
    assign o_render_now  = r_o_render;
    assign o_frames_done = r_o_frames;

endmodule

`default_nettype wire

FILE: hdl/frame_pacing_scheduler.sv
// ----------------------------------------------------------------------------
// frame_pacing_scheduler
// Decides per clock sample whether a tick is due, how long to sleep, and
// whether to simulate and render.
//
// Input channel: i_in_valid / o_in_ready with the time sample, device flag,
// speed index and optional run-mode load. Result channel: o_out_valid /
// i_out_ready with outcome, sleep, poll, simulation steps, render flag and
// frame count. Threshold registers 0..4 are written through i_cfg_wr_en,
// i_cfg_index and i_cfg_data; other indexes are ignored.
// One item at a time. A delayed item goes from accept to result without the
// remainder; any other item first runs the 32-step bit-serial remainder of the
// elapsed time by the selected threshold. The result sits in an output
// register, so a new item is accepted as soon as the previous result is
// written, even while it waits to be taken. If the receiver stalls with a
// result still held, the next result waits inside the block and no further
// item is accepted until it is written.
// Synchronous reset restores the default thresholds, clears time, remainder,
// frame count and run mode, and drops any pending result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module frame_pacing_scheduler (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [fps_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [fps_pkg::THR_W-1:0]     i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [fps_pkg::TIME_W-1:0]    i_now_time,
    input  wire logic                          i_device_present,
    input  wire logic [2:0]                    i_speed_select,
    input  wire logic                          i_mode_load,
    input  wire logic [1:0]                    i_mode_value,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [1:0]                         o_outcome,
    output logic [2:0]                         o_sleep_time,
    output logic                               o_poll_input,
    output logic [2:0]                         o_sim_steps,
    output logic                               o_render_now,
    output logic [fps_pkg::TIME_W-1:0]         o_frames_done
);
    import fps_pkg::*;

    t_cmd cmd;
    t_sts sts;

    fps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    fps_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_now_time       (i_now_time),
        .i_device_present (i_device_present),
        .i_speed_select   (i_speed_select),
        .i_mode_load      (i_mode_load),
        .i_mode_value     (i_mode_value),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_outcome        (o_outcome),
        .o_sleep_time     (o_sleep_time),
        .o_poll_input     (o_poll_input),
        .o_sim_steps      (o_sim_steps),
        .o_render_now     (o_render_now),
        .o_frames_done    (o_frames_done)
    );

endmodule

`default_nettype wire

FILE: hdl/fps_checker.sv
// ----------------------------------------------------------------------------
// fps_checker
// Port-level checks on the frame pacing scheduler results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fps_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [1:0]  i_outcome,
    input  wire logic [2:0]  i_sleep_time,
    input  wire logic [2:0]  i_sim_steps,
    input  wire logic        i_render_now
);
    import fps_pkg::*;

    // a held result stays until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_render: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_render_now |-> i_outcome == OUT_TICKED)
        else $error("render without tick");

    a_sleep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_outcome != OUT_DELAYED |-> i_sleep_time == 3'd0)
        else $error("sleep on non-delayed item");

    a_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_outcome == OUT_DELAYED || i_outcome == OUT_SKIPPED)
        |-> i_sim_steps == 3'd0 && !i_render_now)
        else $error("steps on delayed or skipped item");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind frame_pacing_scheduler fps_checker u_fps_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .i_outcome    (o_outcome),
    .i_sleep_time (o_sleep_time),
    .i_sim_steps  (o_sim_steps),
    .i_render_now (o_render_now)
);

`default_nettype wire
